[sv/rkc_pkg.sv]
// ---------------------------------------------------------------------------
// rkc_pkg
// Shared constants, codes and controller/datapath signal groups for the
// RGB kernel convolution block.
// ---------------------------------------------------------------------------
package rkc_pkg;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_RADIUS     = 2;
  localparam int DEF_COEF_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS     = 8;

  localparam int KIND_W   = 2;
  localparam int CIDX_W   = 5;
  localparam int COEF_W   = 16;
  localparam int CHAN_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_COEF  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd3;

  typedef struct packed {
    logic coef_wr;
    logic pix_wr;
    logic emit_start;
    logic tap_issue;
    logic scale;
    logic load;
  } rkc_cmd_t;

  typedef struct packed {
    logic all_in;
    logic emit_due;
    logic tap_last;
    logic out_free;
  } rkc_sts_t;

endpackage

[sv/rkc_ifs.sv]
// ---------------------------------------------------------------------------
// rkc channel interfaces
// Valid/ready stream interfaces for the input items and the result pixels.
// ---------------------------------------------------------------------------
interface rkc_in_if;
  logic                               valid;
  logic                               ready;
  logic [rkc_pkg::KIND_W-1:0]         kind;
  logic [rkc_pkg::CIDX_W-1:0]         coef_index;
  logic signed [rkc_pkg::COEF_W-1:0]  coef_value;
  logic [rkc_pkg::CHAN_W-1:0]         red;
  logic [rkc_pkg::CHAN_W-1:0]         green;
  logic [rkc_pkg::CHAN_W-1:0]         blue;

  modport source (output valid, kind, coef_index, coef_value, red, green, blue,
                  input ready);
  modport sink   (input valid, kind, coef_index, coef_value, red, green, blue,
                  output ready);
endinterface

interface rkc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rkc_pkg::CHAN_W-1:0] out_red;
  logic [rkc_pkg::CHAN_W-1:0] out_green;
  logic [rkc_pkg::CHAN_W-1:0] out_blue;
  logic                       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end,
                  output ready);
endinterface

[sv/rkc_ram.sv]
// ---------------------------------------------------------------------------
// rkc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module rkc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/rkc_ctrl.sv]
// ---------------------------------------------------------------------------
// rkc_ctrl
// Sequencer: decodes input transactions, steps the kernel taps and hands a
// finished pixel to the output register.
// ---------------------------------------------------------------------------
module rkc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rkc_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  input  rkc_pkg::rkc_sts_t           sts,
  output rkc_pkg::rkc_cmd_t           cmd
);
  import rkc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TAP, S_D1, S_D2, S_SCALE, S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_COEF: cmd.coef_wr = 1'b1;
            KIND_PIXEL: begin
              // A pixel that arrives while draining acts as a flush tick.
              if (sts.all_in) begin
                cmd.emit_start = 1'b1;
                state_nxt      = S_TAP;
              end else begin
                cmd.pix_wr = 1'b1;
                if (sts.emit_due) begin
                  cmd.emit_start = 1'b1;
                  state_nxt      = S_TAP;
                end
              end
            end
            KIND_FLUSH: begin
              if (sts.all_in) begin
                cmd.emit_start = 1'b1;
                state_nxt      = S_TAP;
              end
            end
            default: ;
          endcase
        end
      end
      S_TAP: begin
        cmd.tap_issue = 1'b1;
        if (sts.tap_last) state_nxt = S_D1;
      end
      S_D1:    state_nxt = S_D2;
      S_D2:    state_nxt = S_SCALE;
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free) else $error("result loaded over a waiting one");
  a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_start |-> (sts.all_in || sts.emit_due)) else $error("spurious emit");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_ready) else $error("not idle after result");

endmodule

[sv/rkc_datapath.sv]
// ---------------------------------------------------------------------------
// rkc_datapath
// Configuration registers, coefficient store, line store, frame counters,
// tap multiply-accumulate, gain scaling and the output register.
// ---------------------------------------------------------------------------
module rkc_datapath #(
  parameter int MAX_WIDTH      = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS     = rkc_pkg::DEF_MAX_RADIUS,
  parameter int COEF_FRAC_BITS = rkc_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [rkc_pkg::CIDX_W-1:0]        in_coef_index,
  input  logic signed [rkc_pkg::COEF_W-1:0] in_coef_value,
  input  logic [rkc_pkg::CHAN_W-1:0]        in_red,
  input  logic [rkc_pkg::CHAN_W-1:0]        in_green,
  input  logic [rkc_pkg::CHAN_W-1:0]        in_blue,
  input  rkc_pkg::rkc_cmd_t                 cmd,
  output rkc_pkg::rkc_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rkc_pkg::CHAN_W-1:0]        out_red,
  output logic [rkc_pkg::CHAN_W-1:0]        out_green,
  output logic [rkc_pkg::CHAN_W-1:0]        out_blue,
  output logic                              out_frame_end
);
  import rkc_pkg::*;

  localparam int KSIDE  = 2 * MAX_RADIUS + 1;
  localparam int KSTORE = KSIDE * KSIDE;
  localparam int ROWS   = 3 * MAX_RADIUS + 1;
  localparam int DEPTH  = ROWS * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int RDW    = $clog2(MAX_RADIUS + 1);
  localparam int TW     = $clog2(KSIDE);
  localparam int KIW    = $clog2(KSTORE);
  localparam int SLW    = $clog2(ROWS);
  localparam int SRW    = $clog2(2 * ROWS + MAX_RADIUS + 1);
  localparam int PIXW   = 3 * CHAN_W;
  localparam int PRW    = COEF_W + CHAN_W + 1;
  localparam int ACW    = PRW + $clog2(KSTORE) + 1;
  localparam int SCW    = ACW + 18;
  localparam int SHIFT  = COEF_FRAC_BITS + GAIN_FRAC_BITS;

  // Configuration registers.
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic [15:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
      radius_r <= 2'd1;
      gain_r   <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[10:0];
        CFG_HEIGHT: height_r <= cfg_data[12:0];
        CFG_RADIUS: radius_r <= cfg_data[1:0];
        CFG_GAIN:   gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [RDW-1:0] r_eff;

  always_comb begin
    if (width_r == '0)                  w_eff = CW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else                                w_eff = CW'(width_r);
    if (height_r == '0)                   h_eff = RW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else                                  h_eff = RW'(height_r);
    if (int'(radius_r) > MAX_RADIUS) r_eff = RDW'(MAX_RADIUS);
    else                             r_eff = RDW'(radius_r);
  end

  // Coefficient store: register file read at the running tap index.
  logic signed [COEF_W-1:0] coef_mem [KSTORE];

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && int'(in_coef_index) < KSTORE) begin
      coef_mem[KIW'(in_coef_index)] <= in_coef_value;
    end
  end

  // Frame counters; the slot counters track row modulo the ring depth.
  logic [RW-1:0]  in_row_r, out_row_r;
  logic [CW-1:0]  in_col_r, out_col_r;
  logic [SLW-1:0] in_slot_r, out_slot_r;
  logic           all_in_r;
  logic           in_last, out_last;
  logic [RW+CW-1:0] pos, lag;

  assign in_last  = (in_row_r >= h_eff) ||
                    (in_row_r >= h_eff - RW'(1) && in_col_r >= w_eff - CW'(1));
  assign out_last = (out_row_r >= h_eff) ||
                    (out_row_r >= h_eff - RW'(1) && out_col_r >= w_eff - CW'(1));
  assign pos = (RW+CW)'(in_row_r) * (RW+CW)'(w_eff) + (RW+CW)'(in_col_r);
  assign lag = (RW+CW)'(r_eff) * (RW+CW)'(w_eff) + (RW+CW)'(r_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      all_in_r   <= 1'b0;
    end else if (cmd.load && out_last) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      all_in_r   <= 1'b0;
    end else begin
      if (cmd.pix_wr) begin
        if (in_last) begin
          all_in_r <= 1'b1;
        end else if (in_col_r + CW'(1) >= w_eff) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + RW'(1);
          in_slot_r <= (int'(in_slot_r) == ROWS - 1) ? '0 : in_slot_r + SLW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (cmd.load) begin
        if (out_col_r + CW'(1) >= w_eff) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + RW'(1);
          out_slot_r <= (int'(out_slot_r) == ROWS - 1) ? '0 : out_slot_r + SLW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  // Line store.
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [PIXW-1:0] rd_data;

  assign wr_addr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);

  rkc_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (cmd.pix_wr),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Tap walk: row-major over the (2r+1)^2 kernel positions.
  logic [TW-1:0]  tk_r, tl_r;
  logic [KIW-1:0] ci_r;
  logic [TW-1:0]  tmax;

  assign tmax = TW'({r_eff, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      tk_r <= '0;
      tl_r <= '0;
      ci_r <= '0;
    end else if (cmd.tap_issue) begin
      ci_r <= ci_r + KIW'(1);
      if (tl_r == tmax) begin
        tl_r <= '0;
        tk_r <= tk_r + TW'(1);
      end else begin
        tl_r <= tl_r + TW'(1);
      end
    end
  end

  logic signed [RW+2:0] tap_row;
  logic signed [CW+2:0] tap_col;
  logic [SRW-1:0]       slot_raw;
  logic [SLW-1:0]       tap_slot;
  logic                 tap_inside;

  always_comb begin
    tap_row  = $signed((RW+3)'(out_row_r)) + $signed((RW+3)'(r_eff))
             - $signed((RW+3)'(tk_r));
    tap_col  = $signed((CW+3)'(out_col_r)) + $signed((CW+3)'(r_eff))
             - $signed((CW+3)'(tl_r));
    tap_inside = (tap_row >= 0) && (tap_row < $signed((RW+3)'(h_eff))) &&
                 (tap_col >= 0) && (tap_col < $signed((CW+3)'(w_eff)));
    slot_raw = SRW'(out_slot_r) + SRW'(r_eff) + SRW'(ROWS) - SRW'(tk_r);
    if (int'(slot_raw) >= 2 * ROWS)  tap_slot = SLW'(slot_raw - SRW'(2 * ROWS));
    else if (int'(slot_raw) >= ROWS) tap_slot = SLW'(slot_raw - SRW'(ROWS));
    else                             tap_slot = SLW'(slot_raw);
    rd_addr = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(tap_col[CW-1:0]);
  end

  // MAC pipeline: read and coefficient, then product, then accumulate.
  logic                     v1_r, v2_r;
  logic signed [COEF_W-1:0] coef1_r;
  logic signed [PRW-1:0]    prod_r [3];
  logic signed [ACW-1:0]    acc_r [3];
  logic signed [SCW-1:0]    scaled_r [3];
  logic [CHAN_W-1:0]        chan [3];
  logic [CHAN_W-1:0]        pix_ch [3];

  assign pix_ch[0] = rd_data[23:16];
  assign pix_ch[1] = rd_data[15:8];
  assign pix_ch[2] = rd_data[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.tap_issue && tap_inside;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    coef1_r <= coef_mem[ci_r];
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= $signed({1'b0, pix_ch[c]}) * coef1_r;
      if (cmd.emit_start) begin
        acc_r[c] <= '0;
      end else if (v2_r) begin
        acc_r[c] <= acc_r[c] + ACW'(prod_r[c]);
      end
      if (cmd.scale) begin
        scaled_r[c] <= SCW'(acc_r[c]) * $signed({1'b0, gain_r})
                     + SCW'(1 << (SHIFT - 1));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (scaled_r[c] < 0)                       chan[c] = '0;
      else if ((scaled_r[c] >>> SHIFT) > 255)    chan[c] = '1;
      else                                       chan[c] = scaled_r[c][SHIFT +: CHAN_W];
    end
  end

  // Output register decouples the result side from the sequencer.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_red       <= chan[0];
      out_green     <= chan[1];
      out_blue      <= chan[2];
      out_frame_end <= out_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.all_in   = all_in_r;
  assign sts.emit_due = (pos >= lag);
  assign sts.tap_last = (tk_r == tmax) && (tl_r == tmax);
  assign sts.out_free = !out_valid_r || out_ready;

  a_no_write_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_wr |-> !all_in_r) else $error("pixel stored while draining");
  a_tap_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tap_issue |-> int'(ci_r) < KSTORE) else $error("tap index overrun");
  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !v1_r && !v2_r) else $error("result loaded with taps in flight");

endmodule

[sv/rgb_kernel_convolution.sv]
// ---------------------------------------------------------------------------
// rgb_kernel_convolution
// Zero-padded 2-D RGB convolution of a raster stream with a loadable kernel,
// gain scaling, rounding and clamping.
//
//   channel | direction | contents
//   in_ch   | sink      | coefficient load, pixel or flush transaction
//   out_ch  | source    | result pixel with frame_end
//   cfg_*   | write     | width, height, radius, gain
//
// A coefficient load, a flush or a pixel without result leaves the sequencer
// idle. An item with a result blocks new items until its result is loaded;
// the single line-store read port serves one kernel tap per cycle.
// Reset clears the counters and control; line and coefficient stores are not
// cleared. A waiting result stalls the sequencer only when the next result
// is ready to load.
// ---------------------------------------------------------------------------
module rgb_kernel_convolution #(
  parameter int MAX_WIDTH      = rkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = rkc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS     = rkc_pkg::DEF_MAX_RADIUS,
  parameter int COEF_FRAC_BITS = rkc_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rkc_in_if.sink                         in_ch,
  rkc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rkc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rkc_pkg::*;

  rkc_cmd_t cmd;
  rkc_sts_t sts;

  rkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rkc_datapath #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_RADIUS     (MAX_RADIUS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_coef_index (in_ch.coef_index),
    .in_coef_value (in_ch.coef_value),
    .in_red        (in_ch.red),
    .in_green      (in_ch.green),
    .in_blue       (in_ch.blue),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_red       (out_ch.out_red),
    .out_green     (out_ch.out_green),
    .out_blue      (out_ch.out_blue),
    .out_frame_end (out_ch.frame_end)
  );

endmodule

[verif/tb_rgb_kernel_convolution.sv]
// ---------------------------------------------------------------------------
// tb_rgb_kernel_convolution
// Self-checking bench for the RGB kernel convolution block. Input transactions
// (coefficient loads, pixels, flush ticks and noise) are fed in short frames
// under several register settings. A scoreboard predicts every result pixel
// and compares it field by field with what the block delivers.
// ---------------------------------------------------------------------------
module tb_rgb_kernel_convolution;
  import rkc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int TAPS       = 25;
  localparam int RING_ROWS  = 7;
  localparam int LINE_LEN   = 1024;
  localparam int SETTLE     = 40;
  localparam int CYCLE_CAP  = 800000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } rgb_result_t;

  class rgb_conv_scoreboard;
    bit signed [15:0] taps[TAPS];
    bit [23:0]        lines[RING_ROWS][LINE_LEN];
    int               in_row, in_col, out_row, out_col;
    bit               all_in;
    int unsigned      width_reg = 1024, height_reg = 1024, radius_reg = 1, gain_reg = 256;
    rgb_result_t      pending[$];
    int               errors;
    int               frames_done;
    int               items_fed;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WIDTH:  width_reg = val & 16'h07FF;
        CFG_HEIGHT: height_reg = val & 16'h1FFF;
        CFG_RADIUS: radius_reg = val & 16'h0003;
        CFG_GAIN:   gain_reg = val;
        default: ;
      endcase
    endfunction

    function int eff_w();
      return (width_reg < 1) ? 1 : (width_reg > LINE_LEN ? LINE_LEN : width_reg);
    endfunction

    function int eff_h();
      return (height_reg < 1) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
    endfunction

    function int eff_r();
      return (radius_reg > 2) ? 2 : radius_reg;
    endfunction

    function logic [7:0] scale_chan(longint acc);
      longint t;
      t = acc * longint'(gain_reg) + 64'sd32768;
      if (t < 0) return 8'd0;
      t = t >>> 16;
      return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    // Result at the output position; advances the output counters, or restarts the frame after its last result.
    function void convolve();
      int w, h, r, side, ri, cj, ci;
      longint acc[3];
      bit [23:0] pix;
      rgb_result_t res;
      w = eff_w(); h = eff_h(); r = eff_r();
      side = 2 * r + 1;
      acc = '{0, 0, 0};
      for (int k = -r; k <= r; k++) begin
        for (int l = -r; l <= r; l++) begin
          ri = out_row - k;
          cj = out_col - l;
          ci = (k + r) * side + (l + r);
          if (ri < 0 || ri >= h || cj < 0 || cj >= w) continue;
          pix = lines[ri % RING_ROWS][cj];
          for (int c = 0; c < 3; c++)
            acc[c] += longint'((pix >> (16 - 8 * c)) & 24'hFF) * longint'(taps[ci]);
        end
      end
      res.red = scale_chan(acc[0]);
      res.green = scale_chan(acc[1]);
      res.blue = scale_chan(acc[2]);
      res.frame_end = (out_row >= h) || (out_row >= h - 1 && out_col >= w - 1);
      pending.push_back(res);
      if (res.frame_end) begin
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        all_in = 0;
        frames_done++;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [CIDX_W-1:0] idx,
                             logic [COEF_W-1:0] val, logic [23:0] rgb);
      int w, h, r, pos, lag;
      items_fed++;
      case (kind)
        KIND_COEF: if (idx < TAPS) taps[idx] = val;
        KIND_FLUSH: if (all_in) convolve();
        KIND_PIXEL: begin
          if (all_in) begin
            convolve();
          end else begin
            w = eff_w(); h = eff_h(); r = eff_r();
            if (in_col < LINE_LEN) lines[in_row % RING_ROWS][in_col] = rgb;
            pos = in_row * w + in_col;
            lag = r * w + r;
            if (in_row >= h || (in_row >= h - 1 && in_col >= w - 1)) begin
              all_in = 1;
            end else begin
              in_col++;
              if (in_col >= w) begin
                in_col = 0;
                in_row++;
              end
            end
            if (pos >= lag) convolve();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rgb_result_t act);
      rgb_result_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result %h %h %h end=%b",
                   act.red, act.green, act.blue, act.frame_end);
        return;
      end
      exp_res = pending.pop_front();
      if (act.red !== exp_res.red || act.green !== exp_res.green ||
          act.blue !== exp_res.blue || act.frame_end !== exp_res.frame_end) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result mismatch exp %h %h %h end=%b got %h %h %h end=%b",
                   exp_res.red, exp_res.green, exp_res.blue, exp_res.frame_end,
                   act.red, act.green, act.blue, act.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rkc_in_if  in_ch();
  rkc_out_if out_ch();

  rgb_kernel_convolution dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rgb_conv_scoreboard sb = new();
  bit steady;
  int hold_requests, holds_done, hold_left;
  int cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: checks each transaction and stalls at random and on hold requests.
  always @(posedge clk) begin
    rgb_result_t act;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.red = out_ch.out_red;
      act.green = out_ch.out_green;
      act.blue = out_ch.out_blue;
      act.frame_end = out_ch.frame_end;
      sb.check_result(act);
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_ch.ready <= 1'b0;
      hold_left <= 400;
      holds_done <= hold_requests;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  task automatic send(logic [KIND_W-1:0] kind, logic [CIDX_W-1:0] idx,
                      logic [COEF_W-1:0] val, logic [23:0] rgb);
    while (!steady && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    {in_ch.red, in_ch.green, in_ch.blue} <= rgb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(kind, idx, val, rgb);
  endtask

  task automatic send_pixel(logic [23:0] rgb);
    send(KIND_PIXEL, CIDX_W'($urandom), COEF_W'($urandom), rgb);
  endtask

  task automatic send_flush();
    send(KIND_FLUSH, CIDX_W'($urandom), COEF_W'($urandom), 24'($urandom));
  endtask

  // Registers change only once the block has delivered everything.
  task automatic configure(int unsigned w, int unsigned h, int unsigned r, int unsigned g);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS, CFG_GAIN};
    val = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(r), CFG_DATA_W'(g)};
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_kernel(bit mild);
    for (int i = 0; i < TAPS; i++)
      send(KIND_COEF, CIDX_W'(i),
           mild ? COEF_W'($urandom_range(120) - 40) : COEF_W'($urandom),
           24'($urandom));
  endtask

  function automatic logic [23:0] rand_rgb();
    case ($urandom_range(9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // One frame with noise between pixels, then drained by flush ticks.
  task automatic run_frame(int noise_pct);
    int start;
    start = sb.frames_done;
    while (sb.frames_done == start && !sb.all_in) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send(KIND_SPARE, CIDX_W'($urandom), COEF_W'($urandom), 24'($urandom));
          1: send_flush();
          default: send(KIND_COEF, CIDX_W'($urandom), COEF_W'($urandom_range(120) - 40),
                        24'($urandom));
        endcase
      end else begin
        send_pixel(rand_rgb());
      end
    end
    while (sb.frames_done == start) begin
      // A pixel during the drain counts as a flush tick.
      if ($urandom_range(9) == 0) send_pixel(rand_rgb());
      else send_flush();
    end
    if ($urandom_range(3) == 0) send_flush();
  endtask

  initial begin
    int unsigned w, h, g;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SPARE;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extreme coefficients, ignored loads and kinds, early flush.
    send(KIND_COEF, CIDX_W'(0), 16'h8000, 24'h0);
    send(KIND_COEF, CIDX_W'(24), 16'h7FFF, 24'h0);
    send(KIND_COEF, CIDX_W'(31), 16'hFFFF, 24'hFFFFFF);
    send(KIND_COEF, CIDX_W'(25), 16'h0100, 24'h0);
    send(KIND_SPARE, CIDX_W'(31), 16'hFFFF, 24'hFFFFFF);
    send_flush();
    for (int i = 0; i < TAPS; i++)
      send(KIND_COEF, CIDX_W'(i), (i == 12) ? 16'h0100 : 16'h0020, 24'h0);
    configure(3, 2, 1, 256);
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 24'hFFFFFF : 24'h000000);
    send_pixel(24'h123456);
    for (int i = 0; i < 6; i++) send_flush();
    configure(2, 2, 0, 65535);
    run_frame(0);
    configure(0, 0, 3, 0);
    run_frame(0);

    // Height at its extreme, then shortened while the frame is under way.
    configure(1, 8191, 0, 300);
    repeat (3) send_pixel(rand_rgb());
    configure(1, 3, 0, 300);
    send_pixel(rand_rgb());
    send_flush();

    // Widest row setting, then narrowed while the row is under way.
    configure(2047, 1, 0, 256);
    repeat (20) send_pixel(rand_rgb());
    configure(24, 1, 0, 256);
    run_frame(0);

    // A frame with no idling on either side.
    configure(8, 4, 1, 256);
    steady <= 1'b1;
    run_frame(0);
    steady <= 1'b0;

    while (sb.items_fed < 590) begin
      w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(5))
        0: g = 0;
        1: g = 65535;
        2: g = $urandom_range(65535);
        default: g = $urandom_range(16, 512);
      endcase
      configure(w, h, $urandom_range(3), g);
      if ($urandom_range(2) == 0) load_kernel($urandom_range(3) != 0);
      if ($urandom_range(7) == 0) hold_requests++;
      steady <= ($urandom_range(9) == 0);
      repeat ($urandom_range(1, 3)) run_frame(10);
      steady <= 1'b0;
    end

    // Long receiver stall while pixels keep coming.
    configure(8, 5, 2, 200);
    hold_requests++;
    run_frame(0);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    sb.errors += sb.pending.size();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
